[hw/rtl/cupc_pkg.sv]
// Shared types and constants of the cached permission checker.
// Used by every module of the block; depends on nothing.
package cupc_pkg;

	localparam int unsigned GROUP_REGS = 4;
	localparam logic [11:0] ANY_EXEC = 12'o0111;
	localparam logic [15:0] LIFETIME_RESET = 16'd100;
	localparam int unsigned FOLD_W = 20;
	localparam int unsigned QUOT_W = 19;
	localparam int unsigned RECIP_SH = 31;

	typedef enum logic [2:0] {
		REG_CALLER_UID = 3'd0,
		REG_CALLER_GID = 3'd1,
		REG_GROUP_COUNT = 3'd2,
		REG_EXTRA_GROUP_A = 3'd3,
		REG_EXTRA_GROUP_B = 3'd4,
		REG_EXTRA_GROUP_C = 3'd5,
		REG_EXTRA_GROUP_D = 3'd6,
		REG_CACHE_LIFETIME = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_CHECK = 2'd0,
		KIND_EXIST = 2'd1,
		KIND_INVAL = 2'd2
	} kind_t;

	typedef struct packed {
		logic action;
		logic [31:0] inode_number;
		logic [31:0] file_owner;
		logic [31:0] file_group;
		logic [11:0] file_mode;
		logic [2:0] request_mode;
		logic [31:0] now_ticks;
	} in_t;

	typedef struct packed {
		logic status;
		logic cache_hit;
	} out_t;

	typedef struct packed {
		logic [31:0] caller_uid;
		logic [31:0] caller_gid;
		logic [2:0] group_count;
		logic [GROUP_REGS-1:0][31:0] extra_group;
		logic [15:0] cache_lifetime;
	} cfg_t;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		kind_t kind;
		logic [31:0] inode;
		logic [11:0] mode;
		logic [2:0] req;
		logic [31:0] now;
		logic [31:0] fill_expiry;
		logic miss_denied;
	} item_t;

endpackage

[hw/rtl/cupc_front.sv]
// Front of the checker: accepts requests, decides the miss-path answer and
// computes the cache index. Depends on cupc_pkg.
module cupc_front #(
	parameter int CACHE_ENTRIES = 64,
	parameter int MAX_GROUPS = 4,
	parameter int AW = 6
) (
	input logic clk,
	input logic arst_n,
	input cupc_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_stall,
	input cupc_pkg::in_t in_data,
	output logic push,
	output cupc_pkg::item_t push_item,
	output logic [AW-1:0] push_idx,
	input logic full
);
	// Remainder by the cache size: fold the bytes, then reciprocal multiply.
	localparam int C1 = 256 % CACHE_ENTRIES;
	localparam int C2 = (C1 * 256) % CACHE_ENTRIES;
	localparam int C3 = (C2 * 256) % CACHE_ENTRIES;
	localparam int GLIM = (MAX_GROUPS < 4) ? MAX_GROUPS : 4;
	localparam longint RECIP_L = ((longint'(1) << cupc_pkg::RECIP_SH) + CACHE_ENTRIES - 1)
		/ CACHE_ENTRIES;
	localparam logic [cupc_pkg::FOLD_W-1:0] K1 = cupc_pkg::FOLD_W'(C1);
	localparam logic [cupc_pkg::FOLD_W-1:0] K2 = cupc_pkg::FOLD_W'(C2);
	localparam logic [cupc_pkg::FOLD_W-1:0] K3 = cupc_pkg::FOLD_W'(C3);
	localparam logic [cupc_pkg::FOLD_W-1:0] KN = cupc_pkg::FOLD_W'(CACHE_ENTRIES);
	localparam logic [50:0] RECIP = 51'(RECIP_L);
	localparam logic [2:0] GLIM_V = 3'(GLIM);

	logic v_s1, v_s2;
	cupc_pkg::item_t item_s1, item_s2, item_d;
	logic [cupc_pkg::FOLD_W-1:0] fold_s1, fold_s2, fold_d, rem;
	logic [cupc_pkg::QUOT_W-1:0] quot_s2;
	logic [50:0] prod;
	logic ld1, ld2, acc;
	logic [2:0] n_grp, bits;
	logic in_grp, denied;

	assign push = v_s2 && !full;
	assign ld2 = !v_s2 || push;
	assign ld1 = !v_s1 || ld2;
	assign in_stall = !ld1;
	assign acc = in_valid && ld1;

	always_comb begin
		n_grp = (cfg.group_count > GLIM_V) ? GLIM_V : cfg.group_count;
		in_grp = (cfg.caller_gid == in_data.file_group);
		for (int i = 0; i < cupc_pkg::GROUP_REGS; i++) begin
			if ((3'(i) < n_grp) && (cfg.extra_group[i] == in_data.file_group)) begin
				in_grp = 1'b1;
			end
		end
		if (cfg.caller_uid == in_data.file_owner) begin
			bits = in_data.file_mode[8:6];
		end else if (in_grp) begin
			bits = in_data.file_mode[5:3];
		end else begin
			bits = in_data.file_mode[2:0];
		end
		if (cfg.caller_uid == 32'd0) begin
			denied = in_data.request_mode[0]
				&& ((in_data.file_mode & cupc_pkg::ANY_EXEC) == 12'd0);
		end else begin
			denied = (bits & in_data.request_mode) != in_data.request_mode;
		end
		if (in_data.action) begin
			item_d.kind = cupc_pkg::KIND_INVAL;
		end else if (in_data.request_mode == 3'd0) begin
			item_d.kind = cupc_pkg::KIND_EXIST;
		end else begin
			item_d.kind = cupc_pkg::KIND_CHECK;
		end
		item_d.inode = in_data.inode_number;
		item_d.mode = in_data.file_mode;
		item_d.req = in_data.request_mode;
		item_d.now = in_data.now_ticks;
		item_d.fill_expiry = in_data.now_ticks + 32'(cfg.cache_lifetime);
		item_d.miss_denied = denied;
		fold_d = cupc_pkg::FOLD_W'(in_data.inode_number[7:0])
			+ cupc_pkg::FOLD_W'(in_data.inode_number[15:8]) * K1
			+ cupc_pkg::FOLD_W'(in_data.inode_number[23:16]) * K2
			+ cupc_pkg::FOLD_W'(in_data.inode_number[31:24]) * K3;
	end

	assign prod = 51'(fold_s1) * RECIP;
	assign rem = fold_s2 - cupc_pkg::FOLD_W'(cupc_pkg::FOLD_W'(quot_s2) * KN);
	assign push_idx = rem[AW-1:0];
	assign push_item = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= acc;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item_d;
			fold_s1 <= fold_d;
		end
		if (ld2 && v_s1) begin
			item_s2 <= item_s1;
			fold_s2 <= fold_s1;
			quot_s2 <= cupc_pkg::QUOT_W'(prod >> cupc_pkg::RECIP_SH);
		end
	end

endmodule

[hw/rtl/cupc_queue.sv]
// Two-entry queue between the front and the back of the checker.
// Depends on cupc_pkg for the request type.
module cupc_queue #(
	parameter int AW = 6
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cupc_pkg::item_t push_item,
	input logic [AW-1:0] push_idx,
	output logic full,
	input logic pop,
	output cupc_pkg::item_t head_item,
	output logic [AW-1:0] head_idx,
	output logic empty
);
	cupc_pkg::item_t item_q [2];
	logic [AW-1:0] idx_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head_item = item_q[rd_q];
	assign head_idx = idx_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_q] <= push_item;
			idx_q[wr_q] <= push_idx;
		end
	end

endmodule

[hw/rtl/cupc_back.sv]
// Back of the checker: owns the direct-mapped cache, answers checks,
// sweeps for invalidation and holds the result register. Depends on cupc_pkg.
module cupc_back #(
	parameter int CACHE_ENTRIES = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic arst_n,
	input cupc_pkg::cfg_t cfg,
	input logic empty,
	input cupc_pkg::item_t head_item,
	input logic [AW-1:0] head_idx,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output cupc_pkg::out_t out_data
);
	localparam logic [AW:0] N_V = (AW+1)'(CACHE_ENTRIES);
	localparam logic [AW:0] LAST_V = (AW+1)'(CACHE_ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_LOOK = 4'b0100,
		ST_SWEEP = 4'b1000
	} state_t;

	logic [31:0] inode_mem [CACHE_ENTRIES];
	logic [31:0] user_mem [CACHE_ENTRIES];
	logic [31:0] group_mem [CACHE_ENTRIES];
	logic [11:0] mode_mem [CACHE_ENTRIES];
	logic [31:0] exp_mem [CACHE_ENTRIES];
	logic [31:0] rd_inode_q, rd_user_q, rd_group_q, rd_exp_q;
	logic [11:0] rd_mode_q;

	state_t state_q;
	cupc_pkg::item_t item_q;
	logic [AW-1:0] idx_q, sw_addr_q, rd_addr, wr_addr;
	logic [AW:0] cnt_q;
	logic sw_pend_q, out_valid_q;
	cupc_pkg::out_t out_q, emit_data;
	logic slot_free, hit, hit_denied, we_all, we_exp, emit;
	logic [31:0] wr_exp;

	assign slot_free = !out_valid_q || !out_stall;
	assign hit = (rd_inode_q == item_q.inode) && (rd_user_q == cfg.caller_uid)
		&& (rd_group_q == cfg.caller_gid) && (rd_exp_q > item_q.now);
	assign hit_denied = (rd_mode_q[8:6] & item_q.req) != item_q.req;
	assign pop = (state_q == ST_IDLE) && !empty && slot_free;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		rd_addr = idx_q;
		wr_addr = idx_q;
		wr_exp = item_q.fill_expiry;
		we_all = 1'b0;
		we_exp = 1'b0;
		emit = 1'b0;
		emit_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we_exp = 1'b1;
				wr_addr = cnt_q[AW-1:0];
				wr_exp = 32'd0;
			end
			ST_IDLE: begin
				rd_addr = head_idx;
				emit = pop && (head_item.kind == cupc_pkg::KIND_EXIST);
			end
			ST_LOOK: begin
				emit = slot_free;
				emit_data.status = hit ? hit_denied : item_q.miss_denied;
				emit_data.cache_hit = hit;
				we_all = slot_free && !hit && !item_q.miss_denied;
				we_exp = we_all;
			end
			ST_SWEEP: begin
				rd_addr = (cnt_q < N_V) ? cnt_q[AW-1:0] : '0;
				we_exp = sw_pend_q && (rd_inode_q == item_q.inode);
				wr_addr = sw_addr_q;
				wr_exp = 32'd0;
				emit = (cnt_q == N_V) && slot_free;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_all) begin
			inode_mem[wr_addr] <= item_q.inode;
			user_mem[wr_addr] <= cfg.caller_uid;
			group_mem[wr_addr] <= cfg.caller_gid;
			mode_mem[wr_addr] <= item_q.mode;
		end
		if (we_exp) begin
			exp_mem[wr_addr] <= wr_exp;
		end
		rd_inode_q <= inode_mem[rd_addr];
		rd_user_q <= user_mem[rd_addr];
		rd_group_q <= group_mem[rd_addr];
		rd_mode_q <= mode_mem[rd_addr];
		rd_exp_q <= exp_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head_item;
			idx_q <= head_idx;
		end
		if (emit) begin
			out_q <= emit_data;
		end
		if (state_q == ST_SWEEP) begin
			sw_addr_q <= cnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			sw_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_V) begin
						state_q <= ST_IDLE;
						cnt_q <= '0;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						cnt_q <= '0;
						sw_pend_q <= 1'b0;
						unique case (head_item.kind)
							cupc_pkg::KIND_CHECK: state_q <= ST_LOOK;
							cupc_pkg::KIND_INVAL: state_q <= ST_SWEEP;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOOK: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (cnt_q < N_V) begin
						cnt_q <= cnt_q + 1'b1;
						sw_pend_q <= 1'b1;
					end else begin
						sw_pend_q <= 1'b0;
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A cache fill only ever comes out of a lookup.
	a_fill_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		we_all |-> (state_q == ST_LOOK))
		else $error("cache fill outside lookup");

	// No result can be pending while the expiry store is still being cleared.
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q)
		else $error("result during clearing pass");

	// The sweep counter never runs past the cache size.
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (cnt_q <= N_V))
		else $error("sweep counter overrun");

	// A sweep write follows a read issued during the same sweep.
	a_sweep_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SWEEP) && we_exp) |-> ($past(state_q) == ST_SWEEP))
		else $error("sweep write without a prior read");

endmodule

[hw/rtl/cached_unix_permission_check.sv]
// Top level of the cached permission checker: configuration registers and
// the front, queue and back. Depends on cupc_pkg, cupc_front, cupc_queue, cupc_back.
//
// Usage. Requests arrive on in_valid/in_stall/in_data and are accepted at an
// edge with in_valid high and in_stall low. Each request gives exactly one
// result on out_valid/out_stall/out_data, taken at an edge with out_valid
// high and out_stall low. Configuration is written through cfg_we, cfg_index
// and cfg_data, one register per enabled edge; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// A check passes two front stages (classification, then the index remainder),
// waits at the queue head until the back pops it and reads the cache, and is
// then compared and optionally used to fill the cache; its result is held in
// the output register. An existence request skips the lookup and its result
// is registered at the pop. The back takes no new check before the lookup of
// the last one is done, as it spends a pop and a lookup on each. An invalidate
// walks every cache entry and holds the back until the walk is done.
// After reset the back clears the expiry store, one entry a cycle; requests
// queue up in the front meanwhile.
// When the receiver stalls, the result stays in the output register, the
// back stops, the queue fills and then in_stall rises.
module cached_unix_permission_check #(
	parameter int CACHE_ENTRIES = 64,
	parameter int MAX_GROUPS = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input cupc_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output cupc_pkg::out_t out_data,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	cupc_pkg::cfg_t cfg_q;
	logic push, full, pop, empty;
	cupc_pkg::item_t push_item, head_item;
	logic [AW-1:0] push_idx, head_idx;

	// Configuration registers; the index covers the full list of eight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.caller_uid <= '0;
			cfg_q.caller_gid <= '0;
			cfg_q.group_count <= '0;
			cfg_q.extra_group <= '0;
			cfg_q.cache_lifetime <= cupc_pkg::LIFETIME_RESET;
		end else if (cfg_we) begin
			unique case (cupc_pkg::reg_idx_t'(cfg_index))
				cupc_pkg::REG_CALLER_UID: cfg_q.caller_uid <= cfg_data;
				cupc_pkg::REG_CALLER_GID: cfg_q.caller_gid <= cfg_data;
				cupc_pkg::REG_GROUP_COUNT: cfg_q.group_count <= cfg_data[2:0];
				cupc_pkg::REG_EXTRA_GROUP_A: cfg_q.extra_group[0] <= cfg_data;
				cupc_pkg::REG_EXTRA_GROUP_B: cfg_q.extra_group[1] <= cfg_data;
				cupc_pkg::REG_EXTRA_GROUP_C: cfg_q.extra_group[2] <= cfg_data;
				cupc_pkg::REG_EXTRA_GROUP_D: cfg_q.extra_group[3] <= cfg_data;
				cupc_pkg::REG_CACHE_LIFETIME: cfg_q.cache_lifetime <= cfg_data[15:0];
			endcase
		end
	end

	// The front classifies each request and works out the miss-path answer.
	cupc_front #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.MAX_GROUPS(MAX_GROUPS),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.push(push),
		.push_item(push_item),
		.push_idx(push_idx),
		.full(full)
	);

	// The queue lets the front keep accepting while the back sweeps or waits.
	cupc_queue #(
		.AW(AW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.push_idx(push_idx),
		.full(full),
		.pop(pop),
		.head_item(head_item),
		.head_idx(head_idx),
		.empty(empty)
	);

	// The back owns the cache and the result register.
	cupc_back #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.empty(empty),
		.head_item(head_item),
		.head_idx(head_idx),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
